[src/lpi_pkg.sv]
// ----------------------------------------------------------------------------
// lpi_pkg
// Widths, status codes, register indexes and the item types shared by the
// line / plane intersection unit.
// ----------------------------------------------------------------------------
package lpi_pkg;

    localparam int CW      = 32;           // coordinate width, signed Q16.16
    localparam int TOL_W   = 17;           // tolerance register width
    localparam int DIFF_W  = CW + 1;       // P - L
    localparam int NPROD_W = 2 * CW + 1;   // n * (P - L)
    localparam int NUM_W   = 2 * CW + 3;   // sum of three numerator terms
    localparam int DPROD_W = 2 * CW;       // d * n
    localparam int DEN_W   = 2 * CW + 2;   // sum of three divisor terms
    localparam int ADEN_W  = 2 * CW;       // divisor magnitude
    localparam int ANUM_W  = 2 * CW + 1;   // numerator magnitude
    localparam int ALO_W   = (ANUM_W + 1) / 2;
    localparam int AHI_W   = ANUM_W - ALO_W;
    localparam int N_W     = 3 * CW + 2;   // dividend 2*|num|*|d| + den
    localparam int QB      = CW + 1;       // quotient bits below the overflow bit
    localparam int SEG_W   = 2 * CW + 22;  // segment bound terms
    localparam int QD      = 4;            // job queue depth
    localparam int QA_W    = $clog2(QD);

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NULL_NRM = 3'd1;
    localparam logic [2:0] ST_NULL_DIR = 3'd2;
    localparam logic [2:0] ST_PARALLEL = 3'd3;
    localparam logic [2:0] ST_OUTSIDE  = 3'd4;
    localparam logic [2:0] ST_SAT      = 3'd5;

    localparam logic CFG_SEGMENT = 1'b0;
    localparam logic CFG_TOL     = 1'b1;

    typedef logic [2:0][CW-1:0] t_vec;

    typedef struct packed {
        logic             segment;
        logic [TOL_W-1:0] tol;
    } t_cfg;

    // classified job handed from the front to the back
    typedef struct packed {
        logic [2:0]        status;
        logic              nneg;
        logic [ANUM_W-1:0] anum;
        logic [ADEN_W-1:0] aden;
        t_vec              l;
        t_vec              dmag;
        logic [2:0]        dneg;
    } t_job;

    // one divider stage, three lanes
    typedef struct packed {
        logic [2:0]          status;
        logic [ADEN_W:0]     dvs;
        logic [2:0][N_W-1:0] rem;
        logic [2:0][QB:0]    q;
        t_vec                l;
        logic [2:0]          neg;
    } t_div;

    function automatic logic [CW-1:0] f_mag(input logic [CW-1:0] v);
        return v[CW-1] ? (~v + 1'b1) : v;
    endfunction

endpackage

[src/line_plane_intersection_unit.sv]
// ----------------------------------------------------------------------------
// line_plane_intersection_unit
// Intersection of a line with a plane in signed Q16.16, with status codes.
// ----------------------------------------------------------------------------
// Takes one query per cycle while full is low and returns one result per
// query, in order. Path from push to result: five front stages (dot products
// and classification), the job queue, two product stages, 34 stages of the
// restoring divider (one quotient bit each, three lanes side by side) and the
// result register. The fully pipelined divider sets the rate of one item per
// cycle while results are popped. Registers are written through the cfg
// channel, which is always ready; write them only while idle.
module line_plane_intersection_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [lpi_pkg::TOL_W-1:0]    i_cfg_data,
    input  logic                         push,
    output logic                         full,
    input  logic signed [lpi_pkg::CW-1:0] i_plane_pos_x,
    input  logic signed [lpi_pkg::CW-1:0] i_plane_pos_y,
    input  logic signed [lpi_pkg::CW-1:0] i_plane_pos_z,
    input  logic signed [lpi_pkg::CW-1:0] i_normal_x,
    input  logic signed [lpi_pkg::CW-1:0] i_normal_y,
    input  logic signed [lpi_pkg::CW-1:0] i_normal_z,
    input  logic signed [lpi_pkg::CW-1:0] i_line_pos_x,
    input  logic signed [lpi_pkg::CW-1:0] i_line_pos_y,
    input  logic signed [lpi_pkg::CW-1:0] i_line_pos_z,
    input  logic signed [lpi_pkg::CW-1:0] i_dir_x,
    input  logic signed [lpi_pkg::CW-1:0] i_dir_y,
    input  logic signed [lpi_pkg::CW-1:0] i_dir_z,
    output logic                         empty,
    input  logic                         pop,
    output logic signed [lpi_pkg::CW-1:0] o_hit_x,
    output logic signed [lpi_pkg::CW-1:0] o_hit_y,
    output logic signed [lpi_pkg::CW-1:0] o_hit_z,
    output logic [2:0]                   o_status
);
    import lpi_pkg::*;

    t_cfg r_cfg;
    t_vec p, n, l, d, hit;
    t_job f_job, q_job;
    logic f_valid, q_full, q_empty, q_pop;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.segment <= 1'b0;
            r_cfg.tol     <= TOL_W'(1);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_SEGMENT: r_cfg.segment <= i_cfg_data[0];
                CFG_TOL:     r_cfg.tol     <= i_cfg_data;
                default:     r_cfg         <= r_cfg;
            endcase
        end
    end

    assign p = {i_plane_pos_z, i_plane_pos_y, i_plane_pos_x};
    assign n = {i_normal_z, i_normal_y, i_normal_x};
    assign l = {i_line_pos_z, i_line_pos_y, i_line_pos_x};
    assign d = {i_dir_z, i_dir_y, i_dir_x};

    lpi_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_push      (push),
        .o_full      (full),
        .i_p         (p),
        .i_n         (n),
        .i_l         (l),
        .i_d         (d),
        .o_job_valid (f_valid),
        .i_job_ready (!q_full),
        .o_job       (f_job)
    );

    lpi_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (q_job)
    );

    lpi_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (!q_empty),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_hit       (hit),
        .o_status    (o_status)
    );

    assign o_hit_x = hit[0];
    assign o_hit_y = hit[1];
    assign o_hit_z = hit[2];

endmodule

[src/lpi_front.sv]
// ----------------------------------------------------------------------------
// lpi_front
// Five-stage front: dot products, null / parallel / segment classification.
// ----------------------------------------------------------------------------
module lpi_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  lpi_pkg::t_cfg i_cfg,
    input  logic          i_push,
    output logic          o_full,
    input  lpi_pkg::t_vec i_p,
    input  lpi_pkg::t_vec i_n,
    input  lpi_pkg::t_vec i_l,
    input  lpi_pkg::t_vec i_d,
    output logic          o_job_valid,
    input  logic          i_job_ready,
    output lpi_pkg::t_job o_job
);
    import lpi_pkg::*;

    logic f_en;

    logic                     r1_v, r2_v, r3_v, r4_v, r5_v;
    logic [2:0]               r1_st, r2_st, r3_st, r4_st;
    t_vec                     r1_n, r1_d, r1_l, r2_d, r2_l, r3_d, r3_l, r4_d, r4_l;
    logic [2:0][DIFF_W-1:0]   r1_diff;
    logic [2:0][NPROD_W-1:0]  r2_np;
    logic [2:0][DPROD_W-1:0]  r2_dp;
    logic [NUM_W-1:0]         r3_num, r4_num;
    logic [DEN_W-1:0]         r3_den;
    logic [ADEN_W-1:0]        r4_aden;
    logic [CW+TOL_W-1:0]      r4_tlo, r4_thi;
    t_job                     r5_job;

    logic [2:0]               n1_st;
    logic [2:0][DIFF_W-1:0]   n1_diff;
    logic [2:0][NPROD_W-1:0]  n2_np;
    logic [2:0][DPROD_W-1:0]  n2_dp;
    logic [NUM_W-1:0]         n3_num, n4_num;
    logic [DEN_W-1:0]         n3_den, n4_dabs;
    logic [2:0]               n4_st;
    t_job                     n5_job;

    assign f_en        = !r5_v || i_job_ready;
    assign o_full      = !f_en;
    assign o_job_valid = r5_v;
    assign o_job       = r5_job;

    // stage 1: null tests and P - L
    always_comb begin
        logic null_n, null_d;
        null_n = 1'b1;
        null_d = 1'b1;
        for (int i = 0; i < 3; i++) begin
            if (f_mag(i_n[i]) > CW'(i_cfg.tol)) null_n = 1'b0;
            if (f_mag(i_d[i]) > CW'(i_cfg.tol)) null_d = 1'b0;
            n1_diff[i] = {i_p[i][CW-1], i_p[i]} - {i_l[i][CW-1], i_l[i]};
        end
        n1_st = null_n ? ST_NULL_NRM : (null_d ? ST_NULL_DIR : ST_OK);
    end

    // stage 2: products
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n2_np[i] = NPROD_W'($signed(r1_n[i]) * $signed(r1_diff[i]));
            n2_dp[i] = DPROD_W'($signed(r1_d[i]) * $signed(r1_n[i]));
        end
    end

    // stage 3: sums
    always_comb begin
        n3_num = '0;
        n3_den = '0;
        for (int i = 0; i < 3; i++) begin
            n3_num = n3_num + {{(NUM_W-NPROD_W){r2_np[i][NPROD_W-1]}}, r2_np[i]};
            n3_den = n3_den + {{(DEN_W-DPROD_W){r2_dp[i][DPROD_W-1]}}, r2_dp[i]};
        end
    end

    // stage 4: make the divisor positive, parallel test
    always_comb begin
        logic dn;
        dn      = r3_den[DEN_W-1];
        n4_num  = dn ? (~r3_num + 1'b1) : r3_num;
        n4_dabs = dn ? (~r3_den + 1'b1) : r3_den;
        if (r3_st != ST_OK)
            n4_st = r3_st;
        else if (n4_dabs[ADEN_W-1:0] <= {{(ADEN_W-TOL_W-16){1'b0}}, i_cfg.tol, 16'b0})
            n4_st = ST_PARALLEL;
        else
            n4_st = ST_OK;
    end

    // stage 5: segment bounds, pack the job
    always_comb begin
        logic [SEG_W-1:0] dt, n16, lowt, hight;
        logic [NUM_W-1:0] nabs;
        dt    = (SEG_W'(r4_thi) << CW) + SEG_W'(r4_tlo);
        n16   = {{(SEG_W-NUM_W){r4_num[NUM_W-1]}}, r4_num} << 16;
        lowt  = n16 + dt;
        hight = (SEG_W'(r4_aden) << 16) + dt - n16;
        nabs  = r4_num[NUM_W-1] ? (~r4_num + 1'b1) : r4_num;
        n5_job.status = r4_st;
        if (r4_st == ST_OK && i_cfg.segment && (lowt[SEG_W-1] || hight[SEG_W-1]))
            n5_job.status = ST_OUTSIDE;
        n5_job.nneg = r4_num[NUM_W-1];
        n5_job.anum = nabs[ANUM_W-1:0];
        n5_job.aden = r4_aden;
        n5_job.l    = r4_l;
        for (int i = 0; i < 3; i++) begin
            n5_job.dmag[i] = f_mag(r4_d[i]);
            n5_job.dneg[i] = r4_d[i][CW-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
            r3_v <= 1'b0;
            r4_v <= 1'b0;
            r5_v <= 1'b0;
        end else if (f_en) begin
            r1_v <= i_push;
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            r5_v <= r4_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (f_en) begin
            r1_st   <= n1_st;
            r1_n    <= i_n;
            r1_d    <= i_d;
            r1_l    <= i_l;
            r1_diff <= n1_diff;
            r2_st   <= r1_st;
            r2_d    <= r1_d;
            r2_l    <= r1_l;
            r2_np   <= n2_np;
            r2_dp   <= n2_dp;
            r3_st   <= r2_st;
            r3_d    <= r2_d;
            r3_l    <= r2_l;
            r3_num  <= n3_num;
            r3_den  <= n3_den;
            r4_st   <= n4_st;
            r4_d    <= r3_d;
            r4_l    <= r3_l;
            r4_num  <= n4_num;
            r4_aden <= n4_dabs[ADEN_W-1:0];
            r4_tlo  <= n4_dabs[CW-1:0] * i_cfg.tol;
            r4_thi  <= n4_dabs[ADEN_W-1:CW] * i_cfg.tol;
            r5_job  <= n5_job;
        end
    end

endmodule

[src/lpi_queue.sv]
// ----------------------------------------------------------------------------
// lpi_queue
// Short job queue between the front and the back.
// ----------------------------------------------------------------------------
module lpi_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lpi_pkg::t_job i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output lpi_pkg::t_job o_data
);
    import lpi_pkg::*;

    t_job            r_mem [QD];
    logic [QA_W-1:0] r_wr, r_rd;
    logic [QA_W:0]   r_cnt;
    logic            do_push, do_pop;

    assign o_full  = (r_cnt == (QA_W+1)'(QD));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_cnt <= r_cnt + (QA_W+1)'(do_push) - (QA_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_data;
    end

endmodule

[src/lpi_back.sv]
// ----------------------------------------------------------------------------
// lpi_back
// Back end: offset products, pipelined restoring divider, add and clamp.
// ----------------------------------------------------------------------------
module lpi_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_job_valid,
    input  lpi_pkg::t_job i_job,
    output logic          o_job_pop,
    output logic          o_empty,
    input  logic          i_pop,
    output lpi_pkg::t_vec o_hit,
    output logic [2:0]    o_status
);
    import lpi_pkg::*;

    logic b_en;

    logic                           r_b1_v;
    t_job                           r_b1;
    logic [2:0][ALO_W+CW-1:0]       r_plo;
    logic [2:0][AHI_W+CW-1:0]       r_phi;

    logic                           r_dv_v [QB+2];
    t_div                           r_dv   [QB+2];
    t_div                           n_dv0;

    logic                           r_ov;
    t_vec                           r_hit;
    logic [2:0]                     r_status;
    t_vec                           n_hit;
    logic [2:0]                     n_status;

    assign b_en      = !r_ov || i_pop;
    assign o_job_pop = b_en && i_job_valid;
    assign o_empty   = !r_ov;
    assign o_hit     = r_hit;
    assign o_status  = r_status;

    // dividend 2*|num|*|d| + den over divisor 2*den rounds to nearest
    always_comb begin
        logic [N_W-1:0] prod;
        n_dv0.status = r_b1.status;
        n_dv0.dvs    = {r_b1.aden, 1'b0};
        n_dv0.l      = r_b1.l;
        for (int i = 0; i < 3; i++) begin
            prod           = (N_W'(r_phi[i]) << ALO_W) + N_W'(r_plo[i]);
            n_dv0.rem[i]   = (prod << 1) + N_W'(r_b1.aden);
            n_dv0.q[i]     = '0;
            n_dv0.neg[i]   = r_b1.nneg ^ r_b1.dneg[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_v    <= 1'b0;
            r_dv_v[0] <= 1'b0;
        end else if (b_en) begin
            r_b1_v    <= i_job_valid;
            r_dv_v[0] <= r_b1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_b1 <= i_job;
            for (int i = 0; i < 3; i++) begin
                r_plo[i] <= i_job.anum[ALO_W-1:0] * i_job.dmag[i];
                r_phi[i] <= i_job.anum[ANUM_W-1:ALO_W] * i_job.dmag[i];
            end
            r_dv[0] <= n_dv0;
        end
    end

    // one quotient bit per stage, top bit flags overflow
    for (genvar j = 0; j <= QB; j++) begin : g_div
        localparam int S = QB - j;
        t_div n_st;

        always_comb begin
            logic [N_W-1:0] sub;
            n_st = r_dv[j];
            sub  = N_W'(r_dv[j].dvs) << S;
            for (int i = 0; i < 3; i++) begin
                if (r_dv[j].rem[i] >= sub) begin
                    n_st.rem[i]  = r_dv[j].rem[i] - sub;
                    n_st.q[i][S] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n)
                r_dv_v[j+1] <= 1'b0;
            else if (b_en)
                r_dv_v[j+1] <= r_dv_v[j];
        end

        always_ff @(posedge i_clk) begin
            if (b_en) r_dv[j+1] <= n_st;
        end
    end

    // add the offset to L and clamp
    always_comb begin
        logic [CW+2:0] sum;
        logic          sat;
        sat = 1'b0;
        for (int i = 0; i < 3; i++) begin
            if (r_dv[QB+1].neg[i])
                sum = {{3{r_dv[QB+1].l[i][CW-1]}}, r_dv[QB+1].l[i]}
                      - {2'b0, r_dv[QB+1].q[i][QB-1:0]};
            else
                sum = {{3{r_dv[QB+1].l[i][CW-1]}}, r_dv[QB+1].l[i]}
                      + {2'b0, r_dv[QB+1].q[i][QB-1:0]};
            if (r_dv[QB+1].q[i][QB]) begin
                sat      = 1'b1;
                n_hit[i] = r_dv[QB+1].neg[i] ? {1'b1, {(CW-1){1'b0}}}
                                             : {1'b0, {(CW-1){1'b1}}};
            end else if (sum[CW+2:CW-1] != {4{sum[CW+2]}}) begin
                sat      = 1'b1;
                n_hit[i] = sum[CW+2] ? {1'b1, {(CW-1){1'b0}}}
                                     : {1'b0, {(CW-1){1'b1}}};
            end else begin
                n_hit[i] = sum[CW-1:0];
            end
        end
        if (r_dv[QB+1].status != ST_OK) begin
            n_status = r_dv[QB+1].status;
            n_hit    = '0;
        end else begin
            n_status = sat ? ST_SAT : ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_ov <= 1'b0;
        else if (b_en)
            r_ov <= r_dv_v[QB+1];
    end

    always_ff @(posedge i_clk) begin
        if (b_en) begin
            r_hit    <= n_hit;
            r_status <= n_status;
        end
    end

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the line / plane intersection unit. Queries are
// pushed into the unit with random gaps, results are popped with
// random stalls, and every accepted result is checked field by field against
// an exact big-integer prediction of the hit point and status, across several
// segment mode and tolerance settings.
// ----------------------------------------------------------------------------
module testbench;
    import lpi_pkg::*;

    typedef struct {
        logic signed [CW-1:0] f[12];   // plane pos, normal, line pos, dir
    } query_t;

    typedef struct {
        logic [CW-1:0] hit[3];
        logic [2:0]    status;
    } hit_t;

    class hit_scoreboard;
        hit_t          expected_hits[$];
        logic          segment;
        logic [16:0]   tol;
        int            errors;

        function new();
            segment = 1'b0;
            tol     = 17'd1;
            errors  = 0;
        endfunction

        function automatic logic signed [255:0] abs_w(logic signed [255:0] x);
            return (x < 0) ? -x : x;
        endfunction

        // exact intersection: lambda = n.(P-L) / d.n, hit = L + round(lambda*d)
        function void note_query(query_t q);
            logic signed [255:0] p[3], n[3], l[3], d[3];
            logic signed [255:0] num, den, tw, n16, lowt, hight, anum, quo, v;
            logic signed [255:0] cmax, cmin;
            logic [2:0] st;
            hit_t h;
            bit   nneg, neg;
            tw   = $signed({239'd0, tol});
            cmax = 256'sh7fffffff;
            cmin = -256'sh80000000;
            num  = 0;
            den  = 0;
            st   = ST_OK;
            for (int i = 0; i < 3; i++) begin
                p[i] = q.f[i];
                n[i] = q.f[3 + i];
                l[i] = q.f[6 + i];
                d[i] = q.f[9 + i];
                h.hit[i] = '0;
            end
            if (abs_w(n[0]) <= tw && abs_w(n[1]) <= tw && abs_w(n[2]) <= tw)
                st = ST_NULL_NRM;
            else if (abs_w(d[0]) <= tw && abs_w(d[1]) <= tw && abs_w(d[2]) <= tw)
                st = ST_NULL_DIR;
            else begin
                for (int i = 0; i < 3; i++) begin
                    num += n[i] * (p[i] - l[i]);
                    den += d[i] * n[i];
                end
                if (den < 0) begin
                    den = -den;
                    num = -num;
                end
                if (den <= (tw <<< 16))
                    st = ST_PARALLEL;
                else if (segment) begin
                    n16   = num <<< 16;
                    lowt  = n16 + den * tw;
                    hight = den * (tw + 65536) - n16;
                    if (lowt < 0 || hight < 0) st = ST_OUTSIDE;
                end
            end
            if (st == ST_OK) begin
                nneg = num < 0;
                anum = abs_w(num);
                for (int i = 0; i < 3; i++) begin
                    quo = (2 * anum * abs_w(d[i]) + den) / (2 * den);
                    neg = nneg != (d[i] < 0);
                    if (quo > 256'sh4000000000000000) begin
                        v  = neg ? cmin : cmax;
                        st = ST_SAT;
                    end else begin
                        v = neg ? l[i] - quo : l[i] + quo;
                        if (v > cmax) begin
                            v  = cmax;
                            st = ST_SAT;
                        end else if (v < cmin) begin
                            v  = cmin;
                            st = ST_SAT;
                        end
                    end
                    h.hit[i] = v[CW-1:0];
                end
            end
            h.status = st;
            expected_hits.push_back(h);
        endfunction

        function void check_result(hit_t got);
            hit_t e;
            if (expected_hits.size() == 0) begin
                $error("result with no query pending: status %0d", got.status);
                errors++;
                return;
            end
            e = expected_hits.pop_front();
            for (int i = 0; i < 3; i++) begin
                if (got.hit[i] !== e.hit[i]) begin
                    $error("hit_%s expected %0d got %0d", (i == 0) ? "x" : (i == 1) ? "y" : "z",
                           $signed(e.hit[i]), $signed(got.hit[i]));
                    errors++;
                end
            end
            if (got.status !== e.status) begin
                $error("status expected %0d got %0d", e.status, got.status);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_index = CFG_SEGMENT;
    logic [TOL_W-1:0]     i_cfg_data = '0;
    logic                 push = 1'b0;
    logic                 full;
    logic signed [CW-1:0] fld[12] = '{default: '0};
    logic                 empty;
    logic                 pop = 1'b0;
    logic signed [CW-1:0] o_hit_x, o_hit_y, o_hit_z;
    logic [2:0]           o_status;

    hit_scoreboard sb = new();
    bit  quiet     = 1'b0;
    bit  hold_req  = 1'b0;
    int  idle_cnt  = 0;

    always #1 i_clk = ~i_clk;

    line_plane_intersection_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_valid(i_cfg_valid), .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .push(push), .full(full),
        .i_plane_pos_x(fld[0]), .i_plane_pos_y(fld[1]), .i_plane_pos_z(fld[2]),
        .i_normal_x(fld[3]), .i_normal_y(fld[4]), .i_normal_z(fld[5]),
        .i_line_pos_x(fld[6]), .i_line_pos_y(fld[7]), .i_line_pos_z(fld[8]),
        .i_dir_x(fld[9]), .i_dir_y(fld[10]), .i_dir_z(fld[11]),
        .empty(empty), .pop(pop),
        .o_hit_x(o_hit_x), .o_hit_y(o_hit_y), .o_hit_z(o_hit_z), .o_status(o_status)
    );

    // note and check every beat on both sides
    always @(posedge i_clk) begin
        query_t q;
        hit_t   r;
        bit     moved;
        moved = 1'b0;
        if (i_rst_n && push && !full) begin
            for (int i = 0; i < 12; i++) q.f[i] = fld[i];
            sb.note_query(q);
            moved = 1'b1;
        end
        if (i_rst_n && pop && !empty) begin
            r.hit[0] = o_hit_x;
            r.hit[1] = o_hit_y;
            r.hit[2] = o_hit_z;
            r.status = o_status;
            sb.check_result(r);
            moved = 1'b1;
        end
        idle_cnt = moved ? 0 : idle_cnt + 1;
        if (idle_cnt >= 5000) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // result side: random stall bursts, one long hold-off on request
    initial begin
        int stall;
        stall = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                pop <= 1'b0;
                repeat (300) @(posedge i_clk);
                hold_req = 1'b0;
            end else if (stall > 0) begin
                pop <= 1'b0;
                stall--;
            end else if (!quiet && $urandom_range(0, 5) == 0) begin
                pop   <= 1'b0;
                stall = $urandom_range(0, 10);
            end else
                pop <= 1'b1;
        end
    end

    task automatic write_reg(logic idx, logic [TOL_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        if (idx == CFG_SEGMENT) sb.segment = data[0];
        else sb.tol = data;
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic send_query(query_t q);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        push <= 1'b1;
        for (int i = 0; i < 12; i++) fld[i] <= q.f[i];
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic drain();
        push <= 1'b0;
        while (sb.expected_hits.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    function automatic logic signed [CW-1:0] pick_coord(int kind);
        case (kind)
            0:       return $urandom;
            1:       return $signed($urandom_range(0, 1 << 19)) - (1 << 18);
            2:       return $signed($urandom_range(0, 4)) - 2;
            default: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
        endcase
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     shape;
        shape = $urandom_range(0, 9);
        for (int i = 0; i < 12; i++)
            q.f[i] = pick_coord((shape == 0) ? 0 : (shape == 1) ? $urandom_range(0, 3) : 1);
        if (shape == 2) for (int i = 3; i < 6; i++) q.f[i] = pick_coord(2);
        if (shape == 3) for (int i = 9; i < 12; i++) q.f[i] = pick_coord(2);
        if (shape == 4) begin
            // direction lies in the plane
            q.f[9]  = q.f[4];
            q.f[10] = -q.f[3];
            q.f[11] = 0;
        end
        if (shape == 5) begin
            // line starts near the plane point so lambda is small
            for (int i = 0; i < 3; i++) q.f[6 + i] = q.f[i] + pick_coord(2) * 32'sd4096;
        end
        return q;
    endfunction

    function automatic query_t make_query(int a, int b, int c, int d);
        query_t q;
        for (int i = 0; i < 12; i++) q.f[i] = 0;
        q.f[2]  = a;        // plane z
        q.f[5]  = b;        // normal z
        q.f[8]  = c;        // line z
        q.f[11] = d;        // dir z
        q.f[9]  = 32'sh10000;
        return q;
    endfunction

    task automatic directed_set();
        query_t q;
        send_query(make_query(32'sh10000, 0, 0, 32'sh10000));           // null normal
        q = make_query(32'sh10000, 32'sh10000, 0, 0);
        q.f[9] = 0;
        send_query(q);                                                  // null direction
        send_query(make_query(32'sh10000, 32'sh10000, 0, 0));           // parallel
        send_query(make_query(32'sh50000, 32'sh10000, 0, 32'sh10000));  // lambda 5
        send_query(make_query(32'sh8000, 32'sh10000, 0, 32'sh10000));   // lambda 0.5
        send_query(make_query(0, 32'sh10000, 32'sh10000, 32'sh10000));  // lambda -1
        send_query(make_query(32'sh10000, 32'sh10000, 0, 32'sh10000));  // lambda 1
        send_query(make_query(32'sh7fffffff, 32'sh10000, 32'sh80000000, 32'sh10000));
        send_query(make_query(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000));
        q = make_query(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh10001);
        q.f[9] = 32'sh7fffffff;                                         // saturating
        send_query(q);
        q = make_query(32'sh40000000, 2, 0, 2);
        q.f[9] = 32'sh7fffffff;                                         // near tolerance
        send_query(q);
        for (int i = 0; i < 12; i++) q.f[i] = 32'sh80000000;
        send_query(q);
        for (int i = 0; i < 12; i++) q.f[i] = 32'sh7fffffff;
        send_query(q);
        for (int i = 0; i < 12; i++) q.f[i] = $urandom;
        send_query(q);
    endtask

    initial begin
        logic [TOL_W-1:0] tols[6];
        logic             segs[6];
        tols = '{17'd1, 17'd0, 17'd65536, 17'd65536, 17'd300, 17'd0};
        segs = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int ph = 0; ph < 6; ph++) begin
            if (ph == 4) tols[4] = TOL_W'($urandom_range(0, 65536));
            write_reg(CFG_SEGMENT, {16'd0, segs[ph]});
            write_reg(CFG_TOL, tols[ph]);
            if (ph < 2) directed_set();
            if (ph == 2) hold_req = 1'b1;
            if (ph == 5) quiet = 1'b1;
            for (int k = 0; k < 105; k++) begin
                if (ph == 3 && k == 50) begin
                    // pause until every pending result is out
                    push <= 1'b0;
                    while (sb.expected_hits.size() != 0) @(posedge i_clk);
                end
                send_query(random_query());
            end
            drain();
        end
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
